/* rtl/core/psq_pkg.sv */
// ----------------------------------------------------------------------------
// psq_pkg: shared types and constants of the power squelch gate
// Sample width, fixed-point formats, register indexes and item structs.
// ----------------------------------------------------------------------------
package psq_pkg;

    // Sample and power widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int POWER_W      = 2 * SAMPLE_WIDTH;

    // Fixed-point formats: gain in Q1.16, average in Q32.16
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 17;
    localparam int THR_W   = 32;
    localparam int AVG_W   = 48;
    localparam int AVG_HALF_W = AVG_W / 2;
    localparam int ACC_W   = 64;
    localparam int CFG_W   = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b1;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(1);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(655);

    // Queue between the front and the averaging engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_i;
        logic signed [SAMPLE_WIDTH-1:0] out_q;
        logic                           gate_open;
    } result_t;

    typedef struct packed {
        sample_t             sample;
        logic [POWER_W-1:0]  power;
    } queue_entry_t;

endpackage

/* rtl/core/power_squelch_gate.sv */
// ----------------------------------------------------------------------------
// power_squelch_gate: power squelch with a single-pole power average
// Takes one complex sample per item and returns it unchanged, or muted to
// zero, together with a gate_open flag. The front stage registers the
// magnitude squared of each item and hands it through a two-entry queue to
// the averaging engine, which multiplies, then accumulates into the running
// average, then compares with the threshold, and takes no new item until
// the last result is loaded. An item passes the front registers, the queue,
// the product registers and the running average before its result enters
// the output register, so the front keeps accepting items while a result
// waits to be taken, until the queue fills. Write the threshold and gain
// only while no item is in flight; the average clears to zero on reset.
// ----------------------------------------------------------------------------
module power_squelch_gate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  psq_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output psq_pkg::result_t                result,
    input  logic                            cfg_write,
    input  logic [psq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psq_pkg::CFG_W-1:0]       cfg_data
);

    logic [psq_pkg::THR_W-1:0]  threshold_reg;
    logic [psq_pkg::GAIN_W-1:0] gain_reg;
    logic                       push;
    logic                       pop;
    logic                       queue_full;
    logic                       queue_empty;
    psq_pkg::queue_entry_t      push_entry;
    psq_pkg::queue_entry_t      head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= psq_pkg::THRESHOLD_RST;
            gain_reg      <= psq_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                psq_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[psq_pkg::THR_W-1:0];
                psq_pkg::REG_GAIN:      gain_reg      <= cfg_data[psq_pkg::GAIN_W-1:0];
                default:                ;
            endcase
        end
    end

    psq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    psq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    psq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .power_threshold (threshold_reg),
        .smoothing_gain  (gain_reg),
        .head            (head),
        .queue_empty     (queue_empty),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result)
    );

endmodule

/* rtl/core/psq_front.sv */
// ----------------------------------------------------------------------------
// psq_front: input stage of the power squelch gate
// Accepts sample items, squares both parts and pushes the sample with its
// magnitude squared into the queue.
// ----------------------------------------------------------------------------
module psq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  psq_pkg::sample_t             sample,
    output logic                         push,
    output psq_pkg::queue_entry_t        push_entry,
    input  logic                         queue_full
);

    function automatic logic [psq_pkg::SAMPLE_WIDTH-1:0] magnitude_of(
        input logic signed [psq_pkg::SAMPLE_WIDTH-1:0] v
    );
        logic [psq_pkg::SAMPLE_WIDTH-1:0] mag;
        begin
            if (v[psq_pkg::SAMPLE_WIDTH-1])
            begin
                mag = -v;
            end
            else
            begin
                mag = v;
            end
            return mag;
        end
    endfunction

    logic                             valid_reg;
    logic                             valid_next;
    psq_pkg::sample_t                 sample_reg;
    logic [psq_pkg::POWER_W-1:0]      sq_i_reg;
    logic [psq_pkg::POWER_W-1:0]      sq_q_reg;
    logic [psq_pkg::SAMPLE_WIDTH-1:0] mag_i;
    logic [psq_pkg::SAMPLE_WIDTH-1:0] mag_q;
    logic                             accept;

    // Hold the stage while the queue is full
    assign sample_stall = valid_reg & queue_full;
    assign accept       = sample_valid & ~sample_stall;
    assign push         = valid_reg & ~queue_full;

    assign mag_i = magnitude_of(sample.sample_i);
    assign mag_q = magnitude_of(sample.sample_q);

    always_comb
    begin
        valid_next = accept | (valid_reg & queue_full);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the item and the squares of its parts
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            sq_i_reg   <= mag_i * mag_i;
            sq_q_reg   <= mag_q * mag_q;
        end
    end

    // Sum never exceeds 2^(2*SAMPLE_WIDTH-1), so it fits the power width
    always_comb
    begin
        push_entry.sample = sample_reg;
        push_entry.power  = sq_i_reg + sq_q_reg;
    end

endmodule

/* rtl/core/psq_queue.sv */
// ----------------------------------------------------------------------------
// psq_queue: short queue between the front and the averaging engine
// Holds sample items with their power so each side can stall on its own.
// ----------------------------------------------------------------------------
module psq_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  psq_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output psq_pkg::queue_entry_t head,
    output logic                  full,
    output logic                  empty
);

    psq_pkg::queue_entry_t              entry_mem [psq_pkg::QUEUE_DEPTH];
    logic [psq_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [psq_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [psq_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [psq_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [psq_pkg::QCNT_W-1:0]         count_reg;
    logic [psq_pkg::QCNT_W-1:0]         count_next;

    assign full  = (count_reg == psq_pkg::QCNT_W'(psq_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_mem[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == psq_pkg::QPTR_W'(psq_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == psq_pkg::QPTR_W'(psq_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/psq_back.sv */
// ----------------------------------------------------------------------------
// psq_back: averaging engine and gate of the power squelch gate
// Runs the single-pole average over three steps (multiply, accumulate,
// compare) and drives the registered result channel.
// ----------------------------------------------------------------------------
module psq_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [psq_pkg::THR_W-1:0]  power_threshold,
    input  logic [psq_pkg::GAIN_W-1:0] smoothing_gain,
    input  psq_pkg::queue_entry_t      head,
    input  logic                       queue_empty,
    output logic                       pop,
    output logic                       result_valid,
    input  logic                       result_stall,
    output psq_pkg::result_t           result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ACC  = 3'b010,
        ST_CMP  = 3'b100
    } back_state_t;

    localparam int PROD_P_W = psq_pkg::GAIN_W + psq_pkg::POWER_W;
    localparam int PROD_H_W = psq_pkg::GAIN_W + psq_pkg::AVG_HALF_W;

    back_state_t                      state_reg;
    back_state_t                      state_next;
    logic [psq_pkg::AVG_W-1:0]        avg_reg;
    logic [psq_pkg::AVG_W-1:0]        avg_next;
    logic                             result_valid_reg;
    logic                             result_valid_next;
    psq_pkg::result_t                 result_reg;
    psq_pkg::sample_t                 work_sample_reg;
    logic [PROD_P_W-1:0]              prod_p_reg;
    logic [PROD_H_W-1:0]              prod_hi_reg;
    logic [PROD_H_W-1:0]              prod_lo_reg;
    logic [psq_pkg::GAIN_W-1:0]       gain_a;
    logic [psq_pkg::GAIN_W-1:0]       gain_b;
    logic [psq_pkg::ACC_W-1:0]        acc;
    logic [psq_pkg::AVG_W-1:0]        threshold_q;
    logic                             open;
    logic                             load;

    // Saturate alpha at one; the other weight is its complement
    assign gain_a = (smoothing_gain > psq_pkg::GAIN_ONE) ? psq_pkg::GAIN_ONE
                                                        : smoothing_gain;
    assign gain_b = psq_pkg::GAIN_ONE - gain_a;

    // Weighted sum, rounded to nearest, wrapping at the accumulator width
    assign acc = (psq_pkg::ACC_W'(prod_p_reg) << psq_pkg::FRAC_W)
               + (psq_pkg::ACC_W'(prod_hi_reg) << psq_pkg::AVG_HALF_W)
               + psq_pkg::ACC_W'(prod_lo_reg)
               + psq_pkg::ROUND_HALF;

    assign threshold_q = {power_threshold, psq_pkg::FRAC_W'(0)};
    assign open        = (avg_reg >= threshold_q);

    assign pop  = (state_reg == ST_IDLE) & ~queue_empty;
    assign load = (state_reg == ST_CMP) & (~result_valid_reg | ~result_stall);

    always_comb
    begin
        state_next        = state_reg;
        avg_next          = avg_reg;
        result_valid_next = load | (result_valid_reg & result_stall);
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                avg_next   = acc[psq_pkg::FRAC_W +: psq_pkg::AVG_W];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the running average
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            avg_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            avg_reg          <= avg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Take the head item and form the three partial products
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_sample_reg <= head.sample;
            prod_p_reg      <= gain_a * head.power;
            prod_hi_reg     <= gain_b * avg_reg[psq_pkg::AVG_W-1:psq_pkg::AVG_HALF_W];
            prod_lo_reg     <= gain_b * avg_reg[psq_pkg::AVG_HALF_W-1:0];
        end
    end

    // Gate the sample into the result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.out_i     <= open ? work_sample_reg.sample_i : '0;
            result_reg.out_q     <= open ? work_sample_reg.sample_q : '0;
            result_reg.gate_open <= open;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/tb_power_squelch_gate.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_squelch_gate: self-checking bench for the power squelch gate
// A queue-fed driver pushes complex samples with random gaps. A monitor takes
// results under random stall and checks each one against a running model of
// the power average and the gate decision. Threshold and gain are rewritten
// between phases while the block is idle, covering the extreme settings.
// ----------------------------------------------------------------------------
module tb_power_squelch_gate;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int IDLE_PERCENT = 29;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    psq_pkg::sample_t               sample       = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    psq_pkg::result_t               result;
    logic                           cfg_write    = 1'b0;
    logic [psq_pkg::CFG_IDX_W-1:0]  cfg_index    = psq_pkg::REG_THRESHOLD;
    logic [psq_pkg::CFG_W-1:0]      cfg_data     = '0;

    // Model copy of the registers and the running average
    logic [psq_pkg::THR_W-1:0]      threshold_reg = psq_pkg::THRESHOLD_RST;
    logic [psq_pkg::GAIN_W-1:0]     gain_reg      = psq_pkg::GAIN_RST;
    logic [psq_pkg::AVG_W-1:0]      avg_power     = '0;

    psq_pkg::sample_t               sample_backlog[$];
    psq_pkg::result_t               squelch_due[$];

    logic                  no_idle      = 1'b0;
    int                    mismatches   = 0;
    int                    samples_sent = 0;
    int                    results_seen = 0;
    int                    opened_count = 0;
    int                    reg_writes   = 0;
    int                    cycle_count  = 0;

    power_squelch_gate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Update the running average with one sample and form the gate output
    function automatic psq_pkg::result_t squelch_update(input psq_pkg::sample_t s);
        logic [63:0]      sq_i;
        logic [63:0]      sq_q;
        logic [63:0]      power_q16;
        logic [63:0]      weight;
        logic [63:0]      rest;
        logic [63:0]      acc;
        psq_pkg::result_t r;
        sq_i      = 64'(longint'(signed'(s.sample_i)) * longint'(signed'(s.sample_i)));
        sq_q      = 64'(longint'(signed'(s.sample_q)) * longint'(signed'(s.sample_q)));
        power_q16 = (sq_i + sq_q) << psq_pkg::FRAC_W;
        // Saturate a gain above one
        weight    = (gain_reg > psq_pkg::GAIN_ONE) ? 64'(psq_pkg::GAIN_ONE)
                                                   : 64'(gain_reg);
        rest      = 64'(psq_pkg::GAIN_ONE) - weight;
        acc       = weight * power_q16 + rest * 64'(avg_power) + psq_pkg::ROUND_HALF;
        avg_power = acc[psq_pkg::FRAC_W +: psq_pkg::AVG_W];
        r.gate_open = (avg_power >= {threshold_reg, psq_pkg::FRAC_W'(0)});
        r.out_i     = r.gate_open ? s.sample_i : '0;
        r.out_q     = r.gate_open ? s.sample_q : '0;
        return r;
    endfunction

    function automatic logic take_break();
        return !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Driver: hold a stalled item, advance on acceptance, idle at random
    always @(posedge clk)
    begin
        logic free;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            free = !sample_valid || !sample_stall;
            if (sample_valid && !sample_stall)
            begin
                squelch_due.push_back(squelch_update(sample));
                samples_sent++;
            end
            if (free)
            begin
                if (sample_backlog.size() != 0 && !take_break())
                begin
                    sample       <= sample_backlog.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        psq_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (squelch_due.size() == 0)
                begin
                    report_mismatch("result with no sample outstanding");
                end
                else
                begin
                    want = squelch_due.pop_front();
                    if (want.gate_open)
                        opened_count++;
                    if (result.gate_open !== want.gate_open)
                        report_mismatch($sformatf("result %0d gate_open %b, want %b",
                            results_seen, result.gate_open, want.gate_open));
                    if (result.out_i !== want.out_i)
                        report_mismatch($sformatf("result %0d out_i %0d, want %0d",
                            results_seen, result.out_i, want.out_i));
                    if (result.out_q !== want.out_q)
                        report_mismatch($sformatf("result %0d out_q %0d, want %0d",
                            results_seen, result.out_q, want.out_q));
                end
            end
            result_stall <= take_break();
        end
    end

    // Timeout guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
            cycle_count, squelch_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // Write one register and mirror it in the model
    task automatic write_register(
        input logic [psq_pkg::CFG_IDX_W-1:0] idx,
        input logic [psq_pkg::CFG_W-1:0]     data
    );
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == psq_pkg::REG_THRESHOLD)
            threshold_reg = data[psq_pkg::THR_W-1:0];
        else if (idx == psq_pkg::REG_GAIN)
            gain_reg = data[psq_pkg::GAIN_W-1:0];
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every queued sample has been taken and every result checked
    task automatic drain();
        @(negedge clk);
        while (sample_backlog.size() != 0 || sample_valid || squelch_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_sample(input int i_val, input int q_val);
        psq_pkg::sample_t s;
        s.sample_i = i_val[psq_pkg::SAMPLE_WIDTH-1:0];
        s.sample_q = q_val[psq_pkg::SAMPLE_WIDTH-1:0];
        sample_backlog.push_back(s);
    endtask

    // Pick a component at one of several loudness levels
    function automatic int random_part(input int level);
        case (level)
            0:       return int'($urandom_range(127)) - 64;
            1:       return int'($urandom_range(8191)) - 4096;
            2:       return int'($urandom_range(65535)) - 32768;
            default: return $urandom_range(1) ? -32768 : 32767;
        endcase
    endfunction

    // Queue bursts of quiet and loud samples so the average crosses the threshold
    task automatic queue_bursts(input int count);
        int level;
        int run;
        while (count > 0)
        begin
            level = $urandom_range(3);
            if (level == 3 && $urandom_range(3) != 0)
                level = 2;
            run = $urandom_range(40, 5);
            while (run > 0 && count > 0)
            begin
                queue_sample(random_part(level), random_part(level));
                run--;
                count--;
            end
        end
    endtask

    function automatic logic [psq_pkg::CFG_W-1:0] pick_gain();
        logic [psq_pkg::GAIN_W-1:0] g;
        case ($urandom_range(7))
            0:       g = '0;
            1:       g = psq_pkg::GAIN_ONE;
            2:       g = psq_pkg::GAIN_W'($urandom_range(131071, 65537));
            3:       g = psq_pkg::GAIN_W'($urandom_range(1023, 1));
            4:       g = psq_pkg::GAIN_RST;
            5:       g = psq_pkg::GAIN_W'($urandom_range(65535, 1024));
            default: g = psq_pkg::GAIN_W'($urandom_range(131071));
        endcase
        // Bits above the register width are ignored; fill them at random
        return ($urandom() & ~psq_pkg::CFG_W'(2**psq_pkg::GAIN_W - 1))
             | psq_pkg::CFG_W'(g);
    endfunction

    function automatic logic [psq_pkg::CFG_W-1:0] pick_threshold();
        case ($urandom_range(6))
            0:       return '0;
            1:       return psq_pkg::CFG_W'(1);
            2:       return psq_pkg::CFG_W'($urandom_range(8192));
            3:       return psq_pkg::CFG_W'($urandom_range(1 << 25));
            4:       return psq_pkg::CFG_W'($urandom_range(32'h8000_0000));
            5:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int steady_phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: silence stays muted, any loud sample opens
        queue_sample(0, 0);
        queue_sample(32767, 32767);
        queue_sample(-32768, -32768);
        queue_sample(-1, 1);
        drain();

        // Gain of exactly one: the average equals the current power
        write_register(psq_pkg::REG_GAIN, psq_pkg::CFG_W'(psq_pkg::GAIN_ONE));
        write_register(psq_pkg::REG_THRESHOLD, 32'h8000_0000);
        queue_sample(-32768, -32768);
        queue_sample(32767, 32767);
        queue_sample(-32768, 0);
        queue_sample(0, -32768);
        drain();

        // Gain above one saturates; zero threshold keeps the gate open
        write_register(psq_pkg::REG_GAIN, 32'hFFFF_FFFF);
        write_register(psq_pkg::REG_THRESHOLD, 32'h0000_0000);
        queue_sample(0, 0);
        queue_sample(1, -1);
        queue_sample(32767, -32768);
        drain();

        // Gain zero freezes the average; full-scale threshold never opens
        write_register(psq_pkg::REG_GAIN, 32'h0000_0000);
        write_register(psq_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
        queue_sample(-32768, -32768);
        queue_sample(0, 0);
        drain();
        write_register(psq_pkg::REG_THRESHOLD, 32'h0000_0000);
        queue_sample(0, 0);
        queue_sample(12345, -23456);
        drain();

        // Random phases, one of them with no idling on either side
        steady_phase = $urandom_range(RANDOM_PHASES - 1);
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_register(psq_pkg::REG_GAIN, pick_gain());
            write_register(psq_pkg::REG_THRESHOLD, pick_threshold());
            no_idle = (phase == steady_phase);
            queue_bursts(PHASE_ITEMS);
            drain();
        end
        no_idle = 1'b0;

        // Allow for the pipeline depth before closing out
        repeat (10) @(posedge clk);

        $display("Sent %0d samples over %0d register writes and %0d random phases.",
            samples_sent, reg_writes, RANDOM_PHASES);
        $display("Checked %0d results: %0d with the gate open, %0d muted.",
            results_seen, opened_count, results_seen - opened_count);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/psq_pkg.sv
rtl/core/psq_front.sv
rtl/core/psq_queue.sv
rtl/core/psq_back.sv
rtl/core/power_squelch_gate.sv
tb/tb_power_squelch_gate.sv
